// ----- rtl/gst_pkg.sv -----
`timescale 1ns / 1ps

package gst_pkg;

  // Fraction bits of every fixed-point word.
  localparam int FRAC_BITS = 16;

  // Input transaction: a write of one entry, or a run request.
  typedef struct packed {
    logic [1:0]         req_type;
    logic [2:0]         row;
    logic [2:0]         col;
    logic signed [31:0] entry_value;
  } gst_req_t;

  // Output transaction: one entry of the reduced matrix.
  typedef struct packed {
    logic [2:0]         out_row;
    logic [2:0]         out_col;
    logic signed [31:0] out_value;
    logic               saturated;
    logic               last;
  } gst_rsp_t;

  // Request codes.
  localparam logic [1:0] REQ_WR_A = 2'd0;
  localparam logic [1:0] REQ_WR_B = 2'd1;
  localparam logic [1:0] REQ_RUN  = 2'd2;

endpackage

// ----- rtl/gst_ram.sv -----
`timescale 1ns / 1ps

module gst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- rtl/gst_mul.sv -----
`timescale 1ns / 1ps

module gst_mul #(
  parameter int WORD_BITS = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic signed [WORD_BITS-1:0] x_i,
  input  logic signed [WORD_BITS-1:0] y_i,
  output logic                        done_o,
  output logic signed [WORD_BITS-1:0] res_o,
  output logic                        sat_o
);
  import gst_pkg::*;

  localparam int W  = WORD_BITS;
  localparam int CW = $clog2(W);
  localparam logic signed [2*W:0] PMAX = {{(W+2){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [2*W:0] PMIN = {{(W+2){1'b1}}, {(W-1){1'b0}}};

  logic [W-1:0]    mx_q, hi_q, lo_q;
  logic            neg_q, run_q, fin_q, done_q, sat_q;
  logic [CW-1:0]   cnt_q;
  logic [W:0]      step_sum;
  logic [2*W-1:0]  mag;
  logic signed [2*W:0] sprod, qprod;
  logic signed [W-1:0] res_q;

  // One shift-add step per cycle on the magnitudes.
  assign step_sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, mx_q} : {(W+1){1'b0}});

  // Signed product, floored by the fraction shift.
  assign mag   = {hi_q, lo_q};
  assign sprod = neg_q ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  assign qprod = sprod >>> FRAC_BITS;

  // Sequencing of the iterations.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= fin_q;
      fin_q  <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(W - 1)) begin
          run_q <= 1'b0;
          fin_q <= 1'b1;
        end
      end
    end
  end

  // Datapath of the multiplier.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mx_q  <= x_i[W-1] ? W'(-x_i) : W'(x_i);
      lo_q  <= y_i[W-1] ? W'(-y_i) : W'(y_i);
      hi_q  <= '0;
      neg_q <= x_i[W-1] ^ y_i[W-1];
    end else if (run_q) begin
      hi_q <= step_sum[W:1];
      lo_q <= {step_sum[0], lo_q[W-1:1]};
    end
    if (fin_q) begin
      if (qprod > PMAX) begin
        res_q <= PMAX[W-1:0];
        sat_q <= 1'b1;
      end else if (qprod < PMIN) begin
        res_q <= PMIN[W-1:0];
        sat_q <= 1'b1;
      end else begin
        res_q <= qprod[W-1:0];
        sat_q <= 1'b0;
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;
  assign sat_o  = sat_q;

endmodule

// ----- rtl/symmetric_generalized_eig_reduce_core.sv -----
`timescale 1ns / 1ps
// A run computes about n*n*(n+3)/2 products, all on the one shift-add multiplier
// that serves every product, then emits each entry through a read and a load state
// (after a scan of every entry through a read and a check state when WORD_BITS
// exceeds 32). One item is in work at a time.
// Reset clears the sequencer, the output valid, the flag and sets the order
// to 8; the matrix stores hold no defined value until written.
module symmetric_generalized_eig_reduce_core #(
  parameter int MAX_ORDER = 8,
  parameter int WORD_BITS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  gst_pkg::gst_req_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output gst_pkg::gst_rsp_t out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [3:0]        cfg_data_i
);
  import gst_pkg::*;

  localparam int  W    = WORD_BITS;
  localparam int  IW   = MAX_ORDER > 1 ? $clog2(MAX_ORDER) : 1;
  localparam int  DEP  = MAX_ORDER * MAX_ORDER;
  localparam int  AW   = DEP > 1 ? $clog2(DEP) : 1;
  localparam bit  WIDE = W > 32;
  localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [64:0]  WMAX65 = (65'sd1 <<< (W - 1)) - 65'sd1;
  localparam logic signed [64:0]  WMIN65 = -WMAX65 - 65'sd1;
  localparam logic signed [64:0]  OMAX65 = 65'sd2147483647;
  localparam logic signed [64:0]  OMIN65 = -65'sd2147483648;

  // Sequencer states.
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_KRD  = 4'd1;
  localparam logic [3:0] S_KLAT = 4'd2;
  localparam logic [3:0] S_PH   = 4'd3;
  localparam logic [3:0] S_OPRD = 4'd4;
  localparam logic [3:0] S_OPEX = 4'd5;
  localparam logic [3:0] S_MULW = 4'd6;
  localparam logic [3:0] S_SCRD = 4'd7;
  localparam logic [3:0] S_SCCK = 4'd8;
  localparam logic [3:0] S_EMRD = 4'd9;
  localparam logic [3:0] S_EMLD = 4'd10;

  // Sweep phases within one column.
  localparam logic [2:0] PH_COL1  = 3'd0;
  localparam logic [2:0] PH_RANK2 = 3'd1;
  localparam logic [2:0] PH_COL2  = 3'd2;
  localparam logic [2:0] PH_DIAG  = 3'd3;
  localparam logic [2:0] PH_ABOVE = 3'd4;
  localparam logic [2:0] PH_ROWK  = 3'd5;
  localparam logic [2:0] PH_DONE  = 3'd6;

  // Operation kinds.
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_MAC   = 2'd1;
  localparam logic [1:0] OP_MUL   = 2'd2;
  localparam logic [1:0] OP_STORE = 2'd3;

  // Operand sources.
  localparam logic [2:0] SRC_A    = 3'd0;
  localparam logic [2:0] SRC_B    = 3'd1;
  localparam logic [2:0] SRC_PSI  = 3'd2;
  localparam logic [2:0] SRC_BETA = 3'd3;
  localparam logic [2:0] SRC_ACC  = 3'd4;

  logic [3:0]    state_q, state_d;
  logic [2:0]    phase_q, phase_d;
  logic [1:0]    op_q, op_d;
  logic [IW-1:0] k_q, k_d, i_q, i_d, j_q, j_d, nm1_q, nm1_d;
  logic [3:0]    size_q;
  logic          sat_q, sat_d;
  logic signed [W-1:0] acc_q, acc_d, psi_q, psi_d, beta_q, beta_d;
  logic          out_valid_q, out_valid_d;
  gst_rsp_t      out_q, out_d;

  logic [1:0]    kind;
  logic [2:0]    xs, ys;
  logic [IW-1:0] ar, ac, br, bc;

  logic          a_we, b_we;
  logic [AW-1:0] a_waddr, b_waddr, a_raddr, b_raddr;
  logic [W-1:0]  a_wdata, b_wdata, a_rdata, b_rdata;
  logic signed [W-1:0] a_rd, b_rd, x_val, y_val;

  logic          mul_start, mul_done, mul_sat;
  logic signed [W-1:0] mul_res;
  logic signed [W:0]   add_sum;
  logic          add_ovf;
  logic signed [W-1:0] add_res;

  logic          in_acc, wr_ok;
  logic signed [64:0] ev65, a65;
  logic [W-1:0]  wr_val;
  logic [IW-1:0] wr_row, wr_col;
  logic          elem_last;

  function automatic logic [AW-1:0] addr_of(input logic [IW-1:0] r, input logic [IW-1:0] c);
    return AW'(int'(r) * MAX_ORDER + int'(c));
  endfunction

  assign a_rd = a_rdata;
  assign b_rd = b_rdata;

  // Input write decode and clamp to the word range.
  assign in_acc = in_valid_i && !in_stall_o;
  assign wr_ok  = (int'(in_data_i.row) < MAX_ORDER) && (int'(in_data_i.col) < MAX_ORDER) &&
                  (in_data_i.col >= in_data_i.row);
  assign wr_row = IW'(in_data_i.row);
  assign wr_col = IW'(in_data_i.col);
  assign ev65   = 65'(in_data_i.entry_value);
  always_comb begin
    if (ev65 > WMAX65) begin
      wr_val = WMAX;
    end else if (ev65 < WMIN65) begin
      wr_val = WMIN;
    end else begin
      wr_val = W'(ev65);
    end
  end

  // Operation table for each phase of the column sweep.
  always_comb begin
    kind = OP_LOAD;
    xs   = SRC_ACC;
    ys   = SRC_ACC;
    ar   = i_q;
    ac   = k_q;
    br   = i_q;
    bc   = k_q;
    case (phase_q)
      PH_COL1: begin
        case (op_q)
          2'd0: kind = OP_LOAD;
          2'd1: begin
            kind = OP_MAC;
            xs   = SRC_PSI;
            ys   = SRC_B;
          end
          default: kind = OP_STORE;
        endcase
      end
      PH_RANK2: begin
        case (op_q)
          2'd0: begin
            kind = OP_LOAD;
            ac   = j_q;
          end
          2'd1: begin
            kind = OP_MAC;
            xs   = SRC_A;
            ys   = SRC_B;
            br   = j_q;
          end
          2'd2: begin
            kind = OP_MAC;
            xs   = SRC_B;
            ys   = SRC_A;
            ar   = j_q;
          end
          default: begin
            kind = OP_STORE;
            ac   = j_q;
          end
        endcase
      end
      PH_COL2: begin
        case (op_q)
          2'd0: kind = OP_LOAD;
          2'd1: begin
            kind = OP_MAC;
            xs   = SRC_PSI;
            ys   = SRC_B;
          end
          2'd2: begin
            kind = OP_MUL;
            xs   = SRC_ACC;
            ys   = SRC_BETA;
          end
          default: kind = OP_STORE;
        endcase
      end
      PH_DIAG: begin
        ar = k_q;
        case (op_q)
          2'd0: begin
            kind = OP_MUL;
            xs   = SRC_BETA;
            ys   = SRC_A;
          end
          2'd1: begin
            kind = OP_MUL;
            xs   = SRC_ACC;
            ys   = SRC_BETA;
          end
          default: kind = OP_STORE;
        endcase
      end
      PH_ABOVE: begin
        case (op_q)
          2'd0: begin
            kind = OP_LOAD;
            ac   = j_q;
          end
          2'd1: begin
            kind = OP_MAC;
            xs   = SRC_B;
            ys   = SRC_A;
            ar   = k_q;
            ac   = j_q;
          end
          default: begin
            kind = OP_STORE;
            ac   = j_q;
          end
        endcase
      end
      default: begin
        ar = k_q;
        ac = j_q;
        case (op_q)
          2'd0: begin
            kind = OP_MUL;
            xs   = SRC_BETA;
            ys   = SRC_A;
          end
          default: kind = OP_STORE;
        endcase
      end
    endcase
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    case (xs)
      SRC_A:    x_val = a_rd;
      SRC_B:    x_val = b_rd;
      SRC_PSI:  x_val = psi_q;
      SRC_BETA: x_val = beta_q;
      default:  x_val = acc_q;
    endcase
    case (ys)
      SRC_A:    y_val = a_rd;
      SRC_B:    y_val = b_rd;
      SRC_PSI:  y_val = psi_q;
      SRC_BETA: y_val = beta_q;
      default:  y_val = acc_q;
    endcase
  end

  // Saturating accumulate of a product.
  assign add_sum = {acc_q[W-1], acc_q} + {mul_res[W-1], mul_res};
  assign add_ovf = add_sum[W] != add_sum[W-1];
  assign add_res = add_ovf ? (add_sum[W] ? WMIN : WMAX) : add_sum[W-1:0];

  // Memory ports.
  always_comb begin
    a_raddr = addr_of(ar, ac);
    b_raddr = addr_of(br, bc);
    if (state_q == S_KRD) begin
      a_raddr = addr_of(k_q, k_q);
      b_raddr = addr_of(k_q, k_q);
    end else if (state_q == S_SCRD || state_q == S_EMRD) begin
      a_raddr = addr_of(i_q, j_q);
    end
    a_we    = 1'b0;
    a_waddr = addr_of(wr_row, wr_col);
    a_wdata = wr_val;
    if (state_q == S_OPRD && kind == OP_STORE) begin
      a_we    = 1'b1;
      a_waddr = addr_of(ar, ac);
      a_wdata = acc_q;
    end else if (in_acc && wr_ok && in_data_i.req_type == REQ_WR_A) begin
      a_we = 1'b1;
    end
    b_we    = in_acc && wr_ok && in_data_i.req_type == REQ_WR_B;
    b_waddr = addr_of(wr_row, wr_col);
    b_wdata = wr_val;
  end

  gst_ram #(.WIDTH(W), .DEPTH(DEP)) u_a_ram (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (a_waddr),
    .wdata_i (a_wdata),
    .raddr_i (a_raddr),
    .rdata_o (a_rdata)
  );

  gst_ram #(.WIDTH(W), .DEPTH(DEP)) u_b_ram (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (b_waddr),
    .wdata_i (b_wdata),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  gst_mul #(.WORD_BITS(W)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .x_i     (x_val),
    .y_i     (y_val),
    .done_o  (mul_done),
    .res_o   (mul_res),
    .sat_o   (mul_sat)
  );

  assign a65       = 65'(a_rd);
  assign mul_start = (state_q == S_OPEX) && (kind == OP_MAC || kind == OP_MUL);
  assign elem_last = (i_q == nm1_q) && (j_q == nm1_q);

  // Sequencer next state.
  always_comb begin
    int nsel;
    nsel        = 1;
    state_d     = state_q;
    phase_d     = phase_q;
    op_d        = op_q;
    k_d         = k_q;
    i_d         = i_q;
    j_d         = j_q;
    nm1_d       = nm1_q;
    sat_d       = sat_q;
    acc_d       = acc_q;
    psi_d       = psi_q;
    beta_d      = beta_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc && in_data_i.req_type == REQ_RUN) begin
          if (size_q == 4'd0) begin
            nsel = 1;
          end else if (int'(size_q) > MAX_ORDER) begin
            nsel = MAX_ORDER;
          end else begin
            nsel = int'(size_q);
          end
          nm1_d   = IW'(nsel - 1);
          sat_d   = 1'b0;
          k_d     = '0;
          state_d = S_KRD;
        end
      end
      S_KRD: state_d = S_KLAT;
      S_KLAT: begin
        beta_d  = b_rd;
        psi_d   = a_rd >>> 1;
        phase_d = PH_COL1;
        state_d = S_PH;
      end
      S_PH: begin
        op_d    = '0;
        i_d     = '0;
        j_d     = '0;
        state_d = S_OPRD;
        case (phase_q)
          PH_COL1, PH_RANK2, PH_COL2: begin
            if (k_q == '0) begin
              phase_d = phase_q + 3'd1;
              state_d = S_PH;
            end
          end
          PH_DIAG: ;
          PH_ABOVE: begin
            j_d = k_q + 1'b1;
            if (k_q == '0 || k_q == nm1_q) begin
              phase_d = phase_q + 3'd1;
              state_d = S_PH;
            end
          end
          PH_ROWK: begin
            j_d = k_q + 1'b1;
            if (k_q == nm1_q) begin
              phase_d = phase_q + 3'd1;
              state_d = S_PH;
            end
          end
          default: begin
            if (k_q == nm1_q) begin
              state_d = WIDE ? S_SCRD : S_EMRD;
            end else begin
              k_d     = k_q + 1'b1;
              state_d = S_KRD;
            end
          end
        endcase
      end
      S_OPRD: begin
        if (kind == OP_STORE) begin
          op_d    = '0;
          state_d = S_OPRD;
          case (phase_q)
            PH_COL1, PH_COL2: begin
              if (i_q == k_q - 1'b1) begin
                phase_d = phase_q + 3'd1;
                state_d = S_PH;
              end else begin
                i_d = i_q + 1'b1;
              end
            end
            PH_RANK2: begin
              if (j_q == k_q - 1'b1) begin
                if (i_q == k_q - 1'b1) begin
                  phase_d = phase_q + 3'd1;
                  state_d = S_PH;
                end else begin
                  i_d = i_q + 1'b1;
                  j_d = i_q + 1'b1;
                end
              end else begin
                j_d = j_q + 1'b1;
              end
            end
            PH_ABOVE: begin
              if (j_q == nm1_q) begin
                if (i_q == k_q - 1'b1) begin
                  phase_d = phase_q + 3'd1;
                  state_d = S_PH;
                end else begin
                  i_d = i_q + 1'b1;
                  j_d = k_q + 1'b1;
                end
              end else begin
                j_d = j_q + 1'b1;
              end
            end
            PH_ROWK: begin
              if (j_q == nm1_q) begin
                phase_d = phase_q + 3'd1;
                state_d = S_PH;
              end else begin
                j_d = j_q + 1'b1;
              end
            end
            default: begin
              phase_d = phase_q + 3'd1;
              state_d = S_PH;
            end
          endcase
        end else begin
          state_d = S_OPEX;
        end
      end
      S_OPEX: begin
        if (kind == OP_LOAD) begin
          acc_d   = a_rd;
          op_d    = op_q + 2'd1;
          state_d = S_OPRD;
        end else begin
          state_d = S_MULW;
        end
      end
      S_MULW: begin
        if (mul_done) begin
          if (kind == OP_MAC) begin
            acc_d = add_res;
            sat_d = sat_q | mul_sat | add_ovf;
          end else begin
            acc_d = mul_res;
            sat_d = sat_q | mul_sat;
          end
          op_d    = op_q + 2'd1;
          state_d = S_OPRD;
        end
      end
      S_SCRD: state_d = S_SCCK;
      S_SCCK: begin
        if (a65 > OMAX65 || a65 < OMIN65) begin
          sat_d = 1'b1;
        end
        state_d = S_SCRD;
        if (elem_last) begin
          i_d     = '0;
          j_d     = '0;
          state_d = S_EMRD;
        end else if (j_q == nm1_q) begin
          i_d = i_q + 1'b1;
          j_d = i_q + 1'b1;
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      S_EMRD: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = S_EMLD;
        end
      end
      S_EMLD: begin
        out_valid_d       = 1'b1;
        out_d.out_row     = 3'(i_q);
        out_d.out_col     = 3'(j_q);
        out_d.saturated   = sat_q;
        out_d.last        = elem_last;
        if (a65 > OMAX65) begin
          out_d.out_value = 32'sh7FFFFFFF;
        end else if (a65 < OMIN65) begin
          out_d.out_value = 32'sh80000000;
        end else begin
          out_d.out_value = 32'(a65);
        end
        state_d = S_EMRD;
        if (elem_last) begin
          state_d = S_IDLE;
        end else if (j_q == nm1_q) begin
          i_d = i_q + 1'b1;
          j_d = i_q + 1'b1;
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= PH_COL1;
      op_q        <= '0;
      k_q         <= '0;
      i_q         <= '0;
      j_q         <= '0;
      nm1_q       <= '0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
      size_q      <= 4'd8;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      op_q        <= op_d;
      k_q         <= k_d;
      i_q         <= i_d;
      j_q         <= j_d;
      nm1_q       <= nm1_d;
      sat_q       <= sat_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        size_q <= cfg_data_i;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    psi_q  <= psi_d;
    beta_q <= beta_d;
    out_q  <= out_d;
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

endmodule

// ----- rtl/gst_chk.sv -----
`timescale 1ns / 1ps

module gst_chk #(
  parameter int MAX_ORDER = 8
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input gst_pkg::gst_req_t in_data_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input gst_pkg::gst_rsp_t out_data_o
);
  import gst_pkg::*;

  // A stalled output transaction holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output transaction changed");

  // An accepted run request makes the block busy.
  a_run_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_data_i.req_type == REQ_RUN |=> in_stall_o)
    else $error("block took a run without turning busy");

  // Emitted entries lie in the upper triangle when MAX_ORDER is at most 8.
  a_upper: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (MAX_ORDER > 8) || (out_data_o.out_col >= out_data_o.out_row))
    else $error("emitted entry below the diagonal");

  // The flag is the same on every entry of one run.
  a_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_data_o.last |=>
      !out_valid_o || out_data_o.saturated == $past(out_data_o.saturated))
    else $error("saturation flag changed within a run");

endmodule

bind symmetric_generalized_eig_reduce_core gst_chk #(.MAX_ORDER(MAX_ORDER)) u_gst_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
